### rtl/slot_allocator_fence_deferred_free_assert.svh
// Assertion macros used by the allocator RTL.
`ifndef SLOT_ALLOCATOR_FENCE_DEFERRED_FREE_ASSERT_SVH
`define SLOT_ALLOCATOR_FENCE_DEFERRED_FREE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SAF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SAF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/safdf_pkg.sv
package safdf_pkg;
	localparam int unsigned SLOTS_DEF    = 4096;
	localparam int unsigned DEFERRED_DEF = 64;
	localparam int unsigned QUEUES_DEF   = 4;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;
	localparam logic [1:0] OP_FENCE   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_HEAP_FULL = 2'd1;
	localparam logic [1:0] ST_TAB_FULL  = 2'd2;
	localparam logic [1:0] ST_NULL      = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_RD,
		S_CHK,
		S_MOVE,
		S_OUT
	} state_t;
endpackage

### rtl/safdf_ram.sv
module safdf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/slot_allocator_fence_deferred_free.sv
// Slot allocator with a FIFO of freed slots and a table of fence-deferred frees.
// Input channel s_axis_*: one item per operation (allocate, free, release sweep,
// fence report); output channel m_axis_*: exactly one result item per input item.
// max_slots is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce.
// Fence reports and simple frees go from S_POP straight to the output register;
// an allocate that pops the free FIFO passes through S_OUT for the memory read.
// A release sweep takes each deferred entry as read then check for a kept entry,
// check then copy-in of the last entry for a removed one, paced by the single
// read port of the deferred table.
// One item is processed at a time; s_axis_tready is high only in the idle state,
// and a new item is accepted while a previous result still waits in the output
// register; the engine then waits in S_POP until that register is free.
// Reset clears head, tail, counts, high-water mark and completed fences; memory
// contents are not cleared (only written entries are ever read).
// When the receiver stalls, the result holds in the output register and the
// engine waits in S_POP before writing a new result.
module slot_allocator_fence_deferred_free
	import safdf_pkg::*;
#(
	parameter int unsigned SLOTS            = SLOTS_DEF,
	parameter int unsigned DEFERRED_ENTRIES = DEFERRED_DEF,
	parameter int unsigned QUEUES           = QUEUES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,      // max_slots
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] opcode, [13:2] slot_index, [14] slot_is_null, [15] with_queue,
	// [17:16] queue_id, [81:18] fence_value, zero fill to 88
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [11:0] allocated_slot, [13:12] status, [20:14] released_count, zero fill
	output logic [23:0] m_axis_tdata
);
	`include "slot_allocator_fence_deferred_free_assert.svh"

	localparam int unsigned SW = $clog2(SLOTS);
	localparam int unsigned DW = $clog2(DEFERRED_ENTRIES) > 0 ? $clog2(DEFERRED_ENTRIES) : 1;
	localparam int unsigned QW = $clog2(QUEUES) > 0 ? $clog2(QUEUES) : 1;
	localparam int unsigned PW = 12 + 2 + 64;

	state_t state_q, state_d;

	logic [12:0]  max_slots_q;
	logic [SW-1:0] head_q, tail_q;
	logic [SW:0]   fcnt_q;
	logic [SW:0]   hwm_q;
	logic [DW:0]   pcnt_q;
	logic [DW:0]   idx_q;
	logic [63:0]   done_q [QUEUES];

	logic [1:0]  op_q;
	logic [11:0] slot_q;
	logic        null_q, wq_q;
	logic [1:0]  qid_q;
	logic [63:0] fence_q;
	logic [6:0]  rel_q;
	logic [PW-1:0] ent_q;

	logic        ovalid_q;
	logic [23:0] odata_q;

	// memories
	logic          f_we;
	logic [SW-1:0] f_waddr, f_raddr;
	logic [11:0]   f_wdata, f_rdata;
	logic          p_we;
	logic [DW-1:0] p_waddr, p_raddr;
	logic [PW-1:0] p_wdata, p_rdata;

	safdf_ram #(.WIDTH(12), .DEPTH(SLOTS)) u_fifo (
		.clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
	);
	safdf_ram #(.WIDTH(PW), .DEPTH(DEFERRED_ENTRIES)) u_pend (
		.clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
	);

	logic in_acc, out_acc;
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;

	// effective limit min(max_slots, SLOTS)
	logic [SW:0] limit;
	always_comb begin
		if ({19'd0, max_slots_q} < 32'(SLOTS)) limit = (SW+1)'(max_slots_q);
		else limit = (SW+1)'(SLOTS);
	end

	logic [SW-1:0] head_nx, tail_nx;
	assign head_nx = (32'(head_q) + 1 >= SLOTS) ? '0 : head_q + 1'b1;
	assign tail_nx = (32'(tail_q) + 1 >= SLOTS) ? '0 : tail_q + 1'b1;
	logic fifo_full;
	assign fifo_full = (32'(fcnt_q) >= SLOTS);

	// deferred entry being checked
	logic [11:0] e_slot;
	logic [1:0]  e_q;
	logic [63:0] e_fence, e_done;
	logic [QW-1:0] e_qi;
	assign e_slot  = ent_q[11:0];
	assign e_q     = ent_q[13:12];
	assign e_fence = ent_q[77:14];
	assign e_qi    = QW'(32'(e_q) % QUEUES);
	assign e_done  = done_q[e_qi];
	logic [DW:0] last;
	assign last = pcnt_q - 1'b1;

	logic [QW-1:0] in_qi;
	assign in_qi = QW'(32'(qid_q) % QUEUES);

	logic        res_ld;
	logic [23:0] res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		f_we = 1'b0; f_waddr = tail_q; f_wdata = slot_q; f_raddr = head_q;
		p_we = 1'b0; p_waddr = pcnt_q[DW-1:0];
		p_wdata = {fence_q, qid_q, slot_q};
		p_raddr = idx_q[DW-1:0];
		res_ld = 1'b0; res_d = '0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) state_d = S_POP;
			end
			S_POP: begin
				if (!ovalid_q || out_acc) begin
					case (op_q)
						OP_ALLOC: begin
							if (fcnt_q != 0) state_d = S_OUT;
							else begin
								res_ld = 1'b1; state_d = S_IDLE;
								if (hwm_q < limit) res_d = {10'd0, ST_OK, 12'(hwm_q)};
								else res_d = {10'd0, ST_HEAP_FULL, 12'd0};
							end
						end
						OP_FREE: begin
							res_ld = 1'b1; state_d = S_IDLE;
							if (null_q) res_d = {10'd0, ST_NULL, 12'd0};
							else if (!wq_q) begin
								if (fifo_full) res_d = {10'd0, ST_HEAP_FULL, 12'd0};
								else f_we = 1'b1;
							end else if (32'(pcnt_q) >= DEFERRED_ENTRIES)
								res_d = {10'd0, ST_TAB_FULL, 12'd0};
							else p_we = 1'b1;
						end
						OP_RELEASE: begin
							state_d = S_RD;
						end
						default: begin
							res_ld = 1'b1; state_d = S_IDLE;
						end
					endcase
				end
			end
			S_RD: begin
				if (idx_q >= pcnt_q) begin
					res_ld = 1'b1; res_d = {3'd0, rel_q, ST_OK, 12'd0};
					state_d = S_IDLE;
				end else state_d = S_CHK;
			end
			S_CHK: begin
				if (e_fence <= e_done && !fifo_full) begin
					f_we = 1'b1; f_wdata = e_slot;
					p_raddr = last[DW-1:0];
					state_d = S_MOVE;
				end else begin
					// entry kept: fetch the next one
					p_raddr = idx_q[DW-1:0] + 1'b1;
					state_d = S_RD;
				end
			end
			S_MOVE: begin
				// copy last entry into the gap; re-examine this position
				p_we = (idx_q != pcnt_q);
				p_waddr = idx_q[DW-1:0];
				p_wdata = p_rdata;
				state_d = S_CHK;
				if (idx_q == pcnt_q) state_d = S_RD;
			end
			S_OUT: begin
				res_ld = 1'b1; res_d = {10'd0, ST_OK, f_rdata};
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_slots_q <= 13'd4096;
			head_q <= '0; tail_q <= '0; fcnt_q <= '0; hwm_q <= '0;
			pcnt_q <= '0; idx_q <= '0; rel_q <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < QUEUES; i++) done_q[i] <= '0;
		end else begin
			if (cfg_we) max_slots_q <= cfg_wdata;
			if (res_ld) ovalid_q <= 1'b1;
			else if (out_acc) ovalid_q <= 1'b0;
			if (in_acc) begin
				idx_q <= '0; rel_q <= '0;
			end
			if (f_we) begin
				tail_q <= tail_nx;
			end
			if (f_we && !(state_q == S_OUT)) fcnt_q <= fcnt_q + 1'b1;
			if (state_q == S_POP && (!ovalid_q || out_acc)) begin
				if (op_q == OP_ALLOC && fcnt_q != 0) begin
					head_q <= head_nx; fcnt_q <= fcnt_q - 1'b1;
				end else if (op_q == OP_ALLOC && hwm_q < limit) hwm_q <= hwm_q + 1'b1;
				if (op_q == OP_FREE && p_we) pcnt_q <= pcnt_q + 1'b1;
				if (op_q == OP_FENCE) done_q[in_qi] <= fence_q;
			end
			if (state_q == S_CHK) begin
				if (e_fence <= e_done && !fifo_full) begin
					pcnt_q <= last; rel_q <= rel_q + 1'b1;
				end else idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= s_axis_tdata[1:0];
			slot_q  <= s_axis_tdata[13:2];
			null_q  <= s_axis_tdata[14];
			wq_q    <= s_axis_tdata[15];
			qid_q   <= s_axis_tdata[17:16];
			fence_q <= s_axis_tdata[81:18];
		end
		if (state_q == S_RD || state_q == S_MOVE) ent_q <= p_rdata;
		if (res_ld) odata_q <= res_d;
	end

	`SAF_ASSERT_IMPL(a_busy_no_ready, state_q != S_IDLE, !s_axis_tready)
	`SAF_ASSERT_IMPL(a_pcnt_bound, 1'b1, 32'(pcnt_q) <= DEFERRED_ENTRIES)
	`SAF_ASSERT_IMPL(a_fcnt_bound, 1'b1, 32'(fcnt_q) <= SLOTS)
	`SAF_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
